@@ rtl/core/pidtm_pkg.sv @@
// Package: shared types, constants and op tables of the three-mode PID controller.
`default_nettype none
package pidtm_pkg;

    localparam int DATA_W  = 24;
    localparam int COEF_W  = 32;
    localparam int ACC_W   = 40;
    localparam int ERR_W   = DATA_W + 1;
    localparam int X_W     = ACC_W + 1;
    localparam int DIGIT_W = 4;
    localparam int NDIGIT  = COEF_W / DIGIT_W;
    localparam int CNT_W   = $clog2(NDIGIT);
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = COEF_W + X_W;
    localparam int Q_W     = PROD_W - FRAC_W;
    localparam int SUM_W   = 60;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 32;

    localparam logic [IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_OUT_MIN = 3'd1;
    localparam logic [IDX_W-1:0] REG_OUT_MAX = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_A  = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEF_B  = 3'd4;
    localparam logic [IDX_W-1:0] REG_COEF_C  = 3'd5;
    localparam logic [IDX_W-1:0] REG_COEF_D  = 3'd6;
    localparam logic [IDX_W-1:0] REG_COEF_E  = 3'd7;

    localparam logic [DATA_W-1:0] OUT_MIN_RST = DATA_W'(-65280);
    localparam logic [DATA_W-1:0] OUT_MAX_RST = DATA_W'(65280);

    typedef enum logic [1:0] {
        MODE_POS  = 2'd0,
        MODE_VEL  = 2'd1,
        MODE_VPID = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        CS_A, CS_B, CS_C, CS_D, CS_E
    } coef_sel_t;

    typedef enum logic [2:0] {
        XS_E0, XS_E1, XS_E2, XS_DIFF, XS_M2E1, XS_DSUM, XS_FDP
    } x_sel_t;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] out_min;
        logic signed [DATA_W-1:0] out_max;
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
        logic signed [COEF_W-1:0] coef_d;
        logic signed [COEF_W-1:0] coef_e;
    } cfg_t;

    typedef struct packed {
        logic                     start;
        logic signed [COEF_W-1:0] coef;
        logic signed [X_W-1:0]    x;
    } mul_req_t;

    typedef struct packed {
        logic                  done;
        logic signed [Q_W-1:0] q;
    } mul_rsp_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] drive;
        logic                     clamped;
    } res_t;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(ACC_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (v > hi) return hi[ACC_W-1:0];
        if (v < lo) return lo[ACC_W-1:0];
        return v[ACC_W-1:0];
    endfunction

    function automatic coef_sel_t op_coef(input logic [1:0] mode, input logic [IDX_W-1:0] idx);
        coef_sel_t r;
        r = CS_A;
        case (mode)
            MODE_POS: begin
                case (idx)
                    3'd0:    r = CS_B;
                    3'd1:    r = CS_A;
                    default: r = CS_C;
                endcase
            end
            MODE_VEL: begin
                case (idx)
                    3'd0:    r = CS_A;
                    3'd1:    r = CS_B;
                    default: r = CS_C;
                endcase
            end
            default: begin
                case (idx)
                    3'd0:    r = CS_A;
                    3'd1:    r = CS_B;
                    3'd5:    r = CS_D;
                    3'd6:    r = CS_E;
                    default: r = CS_C;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic x_sel_t op_x(input logic [1:0] mode, input logic [IDX_W-1:0] idx);
        x_sel_t r;
        r = XS_E0;
        case (mode)
            MODE_POS: begin
                case (idx)
                    3'd2:    r = XS_DIFF;
                    default: r = XS_E0;
                endcase
            end
            MODE_VEL: begin
                case (idx)
                    3'd0:    r = XS_E0;
                    3'd1:    r = XS_E1;
                    default: r = XS_E2;
                endcase
            end
            default: begin
                case (idx)
                    3'd0:    r = XS_E0;
                    3'd1:    r = XS_E1;
                    3'd2:    r = XS_E0;
                    3'd3:    r = XS_M2E1;
                    3'd4:    r = XS_E2;
                    3'd5:    r = XS_DSUM;
                    default: r = XS_FDP;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic op_last(input logic [1:0] mode, input logic [IDX_W-1:0] idx);
        logic r;
        case (mode)
            MODE_VPID: r = (idx == 3'd6);
            default:   r = (idx == 3'd2);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/pidtm_mul.sv @@
// Digit-serial signed multiplier, one 4-bit coefficient digit per cycle, MSD first.
`default_nettype none
module pidtm_mul
    import pidtm_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    logic [COEF_W-1:0]        c_reg, c_next;
    logic signed [X_W-1:0]    x_reg, x_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     first_reg, first_next;
    logic                     done_reg, done_next;

    logic [DIGIT_W-1:0]          dig;
    logic signed [DIGIT_W:0]     sdig;
    logic signed [X_W+DIGIT_W:0] pp;

    always_comb begin
        dig  = c_reg[COEF_W-1 -: DIGIT_W];
        sdig = first_reg ? {dig[DIGIT_W-1], dig} : {1'b0, dig};
        pp   = x_reg * sdig;
    end

    always_comb begin
        c_next     = c_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        first_next = first_reg;
        done_next  = 1'b0;
        if (req.start) begin
            c_next     = req.coef;
            x_next     = req.x;
            cnt_next   = '0;
            busy_next  = 1'b1;
            first_next = 1'b1;
        end else if (busy_reg) begin
            acc_next   = (first_reg ? PROD_W'(0) : (acc_reg <<< DIGIT_W)) + PROD_W'(pp);
            c_next     = c_reg << DIGIT_W;
            cnt_next   = cnt_reg + CNT_W'(1);
            first_next = 1'b0;
            if (cnt_reg == CNT_W'(NDIGIT - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        c_reg     <= c_next;
        x_reg     <= x_next;
        acc_reg   <= acc_next;
        cnt_reg   <= cnt_next;
        first_reg <= first_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = acc_reg[PROD_W-1:FRAC_W];

endmodule
`default_nettype wire

@@ rtl/core/pidtm_core.sv @@
// Sequencer and state registers: runs the per-mode product list through the serial multiplier.
`default_nettype none
module pidtm_core
    import pidtm_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire cfg_t                     cfg,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [DATA_W-1:0] target,
    input  wire logic signed [DATA_W-1:0] measurement,
    input  wire logic                     restart,
    input  wire logic                     out_free,
    output res_t                          res
);

    state_t state_reg, state_next;
    logic [IDX_W-1:0] op_reg;

    logic signed [ERR_W-1:0]  e0_reg, e1_reg, e2_reg;
    logic signed [ACC_W-1:0]  integ_reg, dp_reg, fdp_reg, dcur_reg;
    logic signed [DATA_W-1:0] last_reg;
    logic signed [SUM_W-1:0]  sum_reg, aux_reg;

    mul_req_t mreq;
    mul_rsp_t mrsp;

    logic                     accept;
    logic signed [X_W-1:0]    x_val;
    logic signed [COEF_W-1:0] c_val;
    logic signed [SUM_W-1:0]  qx, ix, dx, yx, mnx, mxx;
    logic signed [ACC_W-1:0]  isat, inew, dnew, fnew;
    logic signed [DATA_W-1:0] y_out;
    logic                     y_hit;
    logic                     op_end;

    pidtm_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    assign accept = in_valid && in_ready;
    assign op_end = op_last(cfg.mode, op_reg);

    always_comb begin
        case (op_coef(cfg.mode, op_reg))
            CS_A:    c_val = $signed(cfg.coef_a);
            CS_B:    c_val = $signed(cfg.coef_b);
            CS_C:    c_val = $signed(cfg.coef_c);
            CS_D:    c_val = $signed(cfg.coef_d);
            default: c_val = $signed(cfg.coef_e);
        endcase
        case (op_x(cfg.mode, op_reg))
            XS_E0:   x_val = X_W'(e0_reg);
            XS_E1:   x_val = X_W'(e1_reg);
            XS_E2:   x_val = X_W'(e2_reg);
            XS_DIFF: x_val = X_W'(e0_reg) - X_W'(e1_reg);
            XS_M2E1: x_val = -(X_W'(e1_reg) <<< 1);
            XS_DSUM: x_val = X_W'(dcur_reg) + X_W'(dp_reg);
            default: x_val = X_W'(fdp_reg);
        endcase
    end

    always_comb begin
        qx   = SUM_W'($signed(mrsp.q));
        isat = sat_acc(SUM_W'(integ_reg) + qx);
        ix   = SUM_W'(isat);
        dx   = SUM_W'($signed(cfg.coef_d));
        if (ix > dx)       inew = dx[ACC_W-1:0];
        else if (ix < -dx) inew = ACC_W'(-dx);
        else               inew = isat;
        dnew = sat_acc(aux_reg + qx);
        fnew = sat_acc(aux_reg - qx);
        yx   = sum_reg;
        mnx  = SUM_W'($signed(cfg.out_min));
        mxx  = SUM_W'($signed(cfg.out_max));
        if (yx > mxx) begin
            y_out = $signed(cfg.out_max);
            y_hit = 1'b1;
        end else if (yx < mnx) begin
            y_out = $signed(cfg.out_min);
            y_hit = 1'b1;
        end else begin
            y_out = yx[DATA_W-1:0];
            y_hit = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept)
                    state_next = (cfg.mode == MODE_NONE) ? ST_FINISH : ST_ISSUE;
            end
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT: begin
                if (mrsp.done)
                    state_next = op_end ? ST_FINISH : ST_ISSUE;
            end
            ST_FINISH: begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready    = (state_reg == ST_IDLE);
        mreq.start  = (state_reg == ST_ISSUE);
        mreq.coef   = c_val;
        mreq.x      = x_val;
        res.valid   = (state_reg == ST_FINISH) && out_free;
        res.drive   = y_out;
        res.clamped = y_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= '0;
            e0_reg    <= '0;
            e1_reg    <= '0;
            e2_reg    <= '0;
            integ_reg <= '0;
            dp_reg    <= '0;
            fdp_reg   <= '0;
            last_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                op_reg <= '0;
                e0_reg <= ERR_W'(target) - ERR_W'(measurement);
                e1_reg <= restart ? ERR_W'(0) : e0_reg;
                e2_reg <= restart ? ERR_W'(0) : e1_reg;
                if (restart) begin
                    integ_reg <= '0;
                    dp_reg    <= '0;
                    fdp_reg   <= '0;
                    last_reg  <= '0;
                end
                if ((cfg.mode == MODE_VEL || cfg.mode == MODE_VPID) && !restart)
                    sum_reg <= SUM_W'(last_reg);
                else
                    sum_reg <= '0;
            end else if (state_reg == ST_WAIT && mrsp.done) begin
                op_reg <= op_reg + IDX_W'(1);
                if (cfg.mode == MODE_POS && op_reg == 3'd0) begin
                    integ_reg <= inew;
                    sum_reg   <= SUM_W'(inew);
                end else if (cfg.mode == MODE_VPID && op_reg == 3'd2) begin
                    aux_reg <= qx;
                end else if (cfg.mode == MODE_VPID && op_reg == 3'd3) begin
                    aux_reg <= aux_reg + qx;
                end else if (cfg.mode == MODE_VPID && op_reg == 3'd4) begin
                    dcur_reg <= dnew;
                end else if (cfg.mode == MODE_VPID && op_reg == 3'd5) begin
                    aux_reg <= qx;
                end else if (cfg.mode == MODE_VPID && op_reg == 3'd6) begin
                    sum_reg <= sum_reg + SUM_W'(fnew);
                    fdp_reg <= fnew;
                    dp_reg  <= dcur_reg;
                end else begin
                    sum_reg <= sum_reg + qx;
                end
            end else if (res.valid) begin
                last_reg <= y_out;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/pid_three_mode_controller_unit.sv @@
// Top level: config registers, input stream, result register of the PID controller.
// Each input transaction runs the mode's product list through the serial multiplier before m_tvalid:
// modes 0 and 1 run three products, mode 2 runs seven, mode 3 runs none.
// A new input is taken only while the controller is idle, so it waits for the previous result.
// Each product is issued, multiplied digit by digit, then collected; a stalled result blocks the input.
// aresetn (synchronous, active low) clears controller state and loads register defaults.
`default_nettype none
module pid_three_mode_controller_unit
    import pidtm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [47:0]       s_tdata,   // target[23:0], measurement[47:24]
    input  wire logic [0:0]        s_tuser,   // restart
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,   // drive[23:0]
    output logic [0:0]             m_tuser    // clamped
);

    cfg_t cfg_reg;
    res_t res;
    logic out_free;
    logic m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode    <= MODE_POS;
            cfg_reg.out_min <= OUT_MIN_RST;
            cfg_reg.out_max <= OUT_MAX_RST;
            cfg_reg.coef_a  <= '0;
            cfg_reg.coef_b  <= '0;
            cfg_reg.coef_c  <= '0;
            cfg_reg.coef_d  <= '0;
            cfg_reg.coef_e  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE:    cfg_reg.mode    <= cfg_wr_data[1:0];
                REG_OUT_MIN: cfg_reg.out_min <= cfg_wr_data[DATA_W-1:0];
                REG_OUT_MAX: cfg_reg.out_max <= cfg_wr_data[DATA_W-1:0];
                REG_COEF_A:  cfg_reg.coef_a  <= cfg_wr_data[COEF_W-1:0];
                REG_COEF_B:  cfg_reg.coef_b  <= cfg_wr_data[COEF_W-1:0];
                REG_COEF_C:  cfg_reg.coef_c  <= cfg_wr_data[COEF_W-1:0];
                REG_COEF_D:  cfg_reg.coef_d  <= cfg_wr_data[COEF_W-1:0];
                REG_COEF_E:  cfg_reg.coef_e  <= cfg_wr_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    pidtm_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .target      (s_tdata[DATA_W-1:0]),
        .measurement (s_tdata[2*DATA_W-1:DATA_W]),
        .restart     (s_tuser[0]),
        .out_free    (out_free),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_data_reg <= res.drive;
            m_user_reg <= res.clamped;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

endmodule
`default_nettype wire

@@ rtl/core/pidtm_checker.sv @@
// Port-level checker for the PID controller, bound to the top level.
`default_nettype none
module pidtm_checker
    import pidtm_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a transaction is in progress");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind pid_three_mode_controller_unit pidtm_checker u_pidtm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

@@ tb/sv/pid_three_mode_controller_unit_checker.sv @@
// Checker: predicts the controller's drive output and clamp flag from the observed streams and compares.
`default_nettype none
module pid_three_mode_controller_unit_checker
    import pidtm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [47:0]       s_tdata,
    input  wire logic [0:0]        s_tuser,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [23:0]       m_tdata,
    input  wire logic [0:0]        m_tuser,
    output int                     errors,
    output int                     pending,
    output int                     drives_seen,
    output int                     clamps_seen
);

    typedef struct {
        logic [23:0] drive;
        logic        clamped;
    } drive_t;

    drive_t expected_drives[$];

    logic [1:0] mode_r;
    longint omin, omax, ca, cb, cc, cd, ce;
    longint e_p1, e_p2, integ, last_y, d_prev, f_prev;

    function automatic longint sx(logic [63:0] v, int w);
        longint r;
        r = longint'(v << (64 - w));
        return r >>> (64 - w);
    endfunction

    function automatic longint sat40(longint v);
        longint hi;
        hi = (64'sd1 <<< 39) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // floor(c*x/2^16) with the coefficient split to stay within 64 bits
    function automatic longint fxmul(longint c, longint x);
        longint ch, cl;
        ch = c >>> 16;
        cl = c - ch * 65536;
        return x * ch + ((x * cl) >>> 16);
    endfunction

    task automatic report(input string what, input logic [23:0] got, input logic [23:0] exp);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    task automatic predict_tick(input logic [47:0] d, input logic rs);
        longint e0, e1, e2, y, i, dv, fv;
        drive_t r;
        if (rs) begin
            e_p1 = 0; e_p2 = 0; integ = 0; last_y = 0; d_prev = 0; f_prev = 0;
        end
        e0 = sx(d[23:0], 24) - sx(d[47:24], 24);
        e1 = e_p1;
        e2 = e_p2;
        e_p2 = e1;
        e_p1 = e0;
        y = 0;
        r.clamped = 1'b0;
        case (mode_t'(mode_r))
            MODE_POS: begin
                i = sat40(integ + fxmul(cb, e0));
                if (i > cd) i = cd;
                else if (i < -cd) i = -cd;
                integ = i;
                y = fxmul(ca, e0) + i + fxmul(cc, e0 - e1);
            end
            MODE_VEL: y = last_y + fxmul(ca, e0) + fxmul(cb, e1) + fxmul(cc, e2);
            MODE_VPID: begin
                dv = sat40(fxmul(cc, e0) + fxmul(cc, -2 * e1) + fxmul(cc, e2));
                fv = sat40(fxmul(cd, dv + d_prev) - fxmul(ce, f_prev));
                d_prev = dv;
                f_prev = fv;
                y = last_y + fxmul(ca, e0) + fxmul(cb, e1) + fv;
            end
            default: y = 0;
        endcase
        if (y > omax) begin
            y = omax; r.clamped = 1'b1;
        end else if (y < omin) begin
            y = omin; r.clamped = 1'b1;
        end
        last_y = y;
        r.drive = y[23:0];
        expected_drives.push_back(r);
    endtask

    always @(posedge aclk) begin
        drive_t x;
        if (!aresetn) begin
            mode_r = MODE_POS; omin = -65280; omax = 65280;
            ca = 0; cb = 0; cc = 0; cd = 0; ce = 0;
            e_p1 = 0; e_p2 = 0; integ = 0; last_y = 0; d_prev = 0; f_prev = 0;
            expected_drives.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MODE:    mode_r = cfg_wr_data[1:0];
                    REG_OUT_MIN: omin = sx(cfg_wr_data, 24);
                    REG_OUT_MAX: omax = sx(cfg_wr_data, 24);
                    REG_COEF_A:  ca = sx(cfg_wr_data, 32);
                    REG_COEF_B:  cb = sx(cfg_wr_data, 32);
                    REG_COEF_C:  cc = sx(cfg_wr_data, 32);
                    REG_COEF_D:  cd = sx(cfg_wr_data, 32);
                    default:     ce = sx(cfg_wr_data, 32);
                endcase
            end
            if (s_tvalid && s_tready) predict_tick(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready) begin
                if (expected_drives.size() == 0) begin
                    $display("unexpected result transaction %h at %0t", m_tdata, $realtime);
                    errors++;
                end else begin
                    x = expected_drives.pop_front();
                    if (m_tdata !== x.drive) report("drive", m_tdata, x.drive);
                    if (m_tuser[0] !== x.clamped) report("clamped", 24'(m_tuser), 24'(x.clamped));
                    drives_seen++;
                    if (x.clamped) clamps_seen++;
                end
            end
        end
        pending = expected_drives.size();
    end

    initial begin
        errors = 0; pending = 0; drives_seen = 0; clamps_seen = 0;
    end

endmodule
`default_nettype wire

@@ tb/sv/pid_three_mode_controller_unit_test.sv @@
// Testbench top: stimulus, configuration phases and verdict for the PID controller.
`default_nettype none
module pid_three_mode_controller_unit_test;
    import pidtm_pkg::*;

    localparam longint MAX_CYCLES = 2000000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata = '0;   // target[23:0], measurement[47:24]
    logic [0:0]        s_tuser = '0;   // restart
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;        // drive[23:0]
    logic [0:0]        m_tuser;        // clamped
    int                errors, pending, drives_seen, clamps_seen;
    longint            cycles = 0;
    int                ticks_sent = 0;
    bit                hold_off = 1'b0;
    int                modes_run[4];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    pid_three_mode_controller_unit uut (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_wr_data,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    pid_three_mode_controller_unit_checker chk (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_wr_data,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .errors, .pending, .drives_seen, .clamps_seen
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("pid_three_mode_controller_unit_test: FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stalls, plus one long hold-off when requested
    initial begin
        int g;
        int n;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                for (n = 0; n < 400; n++) @(posedge aclk);
                hold_off = 1'b0;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // write enable is left high; callers drop it after the last write
    task automatic wr_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= v;
        @(posedge aclk);
    endtask

    task automatic wait_empty();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic drain();
        wait_empty();
        repeat (80) @(posedge aclk);
    endtask

    task automatic send_tick(input logic [23:0] tgt, input logic [23:0] meas, input logic rs,
                             input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {meas, tgt};
        s_tuser <= rs;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ticks_sent++;
    endtask

    function automatic logic [23:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom);
            default: return 24'($signed($urandom_range(0, 40000)) - 20000);
        endcase
    endfunction

    function automatic logic [31:0] rnd_coef();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    task automatic cfg_phase(input logic [1:0] m);
        logic [23:0] lo, hi;
        wr_reg(REG_MODE, 32'(m));
        case ($urandom_range(0, 3))
            0: begin lo = 24'h800000; hi = 24'h7FFFFF; end
            1: begin lo = 24'($urandom); hi = 24'($urandom); end
            default: begin
                lo = 24'(-$urandom_range(100, 70000));
                hi = 24'($urandom_range(100, 70000));
            end
        endcase
        wr_reg(REG_OUT_MIN, {{8{lo[23]}}, lo});
        wr_reg(REG_OUT_MAX, {{8{hi[23]}}, hi});
        wr_reg(REG_COEF_A, rnd_coef());
        wr_reg(REG_COEF_B, rnd_coef());
        wr_reg(REG_COEF_C, rnd_coef());
        wr_reg(REG_COEF_D, (m == MODE_POS && $urandom_range(0, 1)) ?
                           32'($urandom_range(0, 200000)) : rnd_coef());
        wr_reg(REG_COEF_E, rnd_coef());
        cfg_wr_en <= 1'b0;
        modes_run[m]++;
    endtask

    initial begin
        int p, k;
        logic [1:0] m;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: defaults first, then each mode with moderate gains
        send_tick(24'h7FFFFF, 24'h800000, 1'b0, 1'b0);
        send_tick(24'h800000, 24'h7FFFFF, 1'b0, 1'b0);
        for (m = 0; m < 3; m++) begin
            s_tvalid <= 1'b0;
            drain();
            wr_reg(REG_MODE, 32'(m));
            wr_reg(REG_OUT_MIN, 32'hFFFF0100);
            wr_reg(REG_OUT_MAX, 32'h0000FF00);
            wr_reg(REG_COEF_A, 32'h00010000);
            wr_reg(REG_COEF_B, 32'h00008000);
            wr_reg(REG_COEF_C, 32'hFFFF4000);
            wr_reg(REG_COEF_D, 32'h00004000);
            wr_reg(REG_COEF_E, 32'h00002000);
            cfg_wr_en <= 1'b0;
            send_tick(24'h000500, 24'h000100, 1'b1, 1'b0);
            send_tick(24'h000500, 24'h000300, 1'b0, 1'b0);
            send_tick(24'h7FFFFF, 24'h800000, 1'b0, 1'b0);
            send_tick(24'h000000, 24'h000200, 1'b0, 1'b0);
            send_tick(24'h000100, 24'h000100, 1'b1, 1'b0);
        end
        s_tvalid <= 1'b0;
        drain();
        wr_reg(REG_MODE, 32'(MODE_NONE));
        cfg_wr_en <= 1'b0;
        send_tick(24'h123456, 24'h000000, 1'b0, 1'b0);
        s_tvalid <= 1'b0;
        drain();
        // inverted limits
        wr_reg(REG_MODE, 32'(MODE_VEL));
        wr_reg(REG_OUT_MIN, 32'h00001000);
        wr_reg(REG_OUT_MAX, 32'hFFFFF000);
        cfg_wr_en <= 1'b0;
        send_tick(24'h400000, 24'h000000, 1'b0, 1'b0);
        send_tick(24'hC00000, 24'h000000, 1'b0, 1'b0);
        // random phases
        for (p = 0; p < 30; p++) begin
            s_tvalid <= 1'b0;
            drain();
            m = (p % 10 == 9) ? MODE_NONE : 2'($urandom_range(0, 2));
            cfg_phase(m);
            if (p == 3) hold_off = 1'b1;
            for (k = 0; k < 30; k++)
                send_tick(rnd_val(), rnd_val(), $urandom_range(0, 15) == 0, p != 3);
            if (p == 5) begin
                s_tvalid <= 1'b0;
                wait_empty();
            end
        end
        s_tvalid <= 1'b0;
        drain();
        $display("%0d ticks sent, %0d results checked (%0d clamped)",
                 ticks_sent, drives_seen, clamps_seen);
        $display("phases per mode: pos %0d vel %0d vpid %0d none %0d",
                 modes_run[0], modes_run[1], modes_run[2], modes_run[3]);
        if (errors == 0) begin
            $display("pid_three_mode_controller_unit_test: PASS");
        end else begin
            $display("pid_three_mode_controller_unit_test: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
